FILE: sv/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg
// Types and constants shared by the stream mode finder controller, datapath
// and top level.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int VALUE_W = 32;
  localparam int MODE_COUNT_W = 16;
  localparam logic [MODE_COUNT_W-1:0] MODE_COUNT_MAX = 16'hFFFF;
  localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic load;
    logic match;
    logic update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_blocked;
  } status_t;

endpackage

FILE: sv/smf_ctrl.sv
// ----------------------------------------------------------------------------
// smf_ctrl
// Sequencer for the mode finder: accept an item, match it against the table,
// then update the table and emit the result on the last item.
// ----------------------------------------------------------------------------
module smf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  smf_pkg::status_t status,
  output smf_pkg::cmd_t    cmd
);

  smf_pkg::state_t state;
  smf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      smf_pkg::ST_IDLE: begin
        if (in_valid) state_next = smf_pkg::ST_MATCH;
      end
      smf_pkg::ST_MATCH: begin
        state_next = smf_pkg::ST_UPDATE;
      end
      smf_pkg::ST_UPDATE: begin
        if (!(status.last && status.out_blocked)) state_next = smf_pkg::ST_IDLE;
      end
      default: begin
        state_next = smf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      smf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      smf_pkg::ST_MATCH: begin
        cmd.match = 1'b1;
      end
      smf_pkg::ST_UPDATE: begin
        // hold while the previous result still waits
        if (!(status.last && status.out_blocked)) begin
          cmd.update = 1'b1;
          cmd.emit = status.last;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: sv/smf_datapath.sv
// ----------------------------------------------------------------------------
// smf_datapath
// Associative value table with per-entry counts, running mode tracking and
// the result register.
// ----------------------------------------------------------------------------
module smf_datapath #(
  parameter int DISTINCT = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  smf_pkg::cmd_t                        cmd,
  output smf_pkg::status_t                     status,
  input  logic signed [smf_pkg::VALUE_W-1:0]   value,
  input  logic                                 has_value,
  input  logic                                 last,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [smf_pkg::VALUE_W-1:0]   mode_value,
  output logic [smf_pkg::MODE_COUNT_W-1:0]     mode_count,
  output logic                                 empty_list,
  output logic                                 table_overflow
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam int WIDE_W = (COUNT_BITS > smf_pkg::MODE_COUNT_W) ?
                          COUNT_BITS : smf_pkg::MODE_COUNT_W;

  logic signed [smf_pkg::VALUE_W-1:0] value_q;
  logic                               has_q;
  logic                               last_q;

  logic signed [smf_pkg::VALUE_W-1:0] key_store [DISTINCT];
  logic [COUNT_BITS-1:0]              count_store [DISTINCT];
  logic [DISTINCT-1:0]                entry_valid;

  logic signed [smf_pkg::VALUE_W-1:0] best_value;
  logic [COUNT_BITS-1:0]              best_count;
  logic                               overflow_seen;
  logic                               any_seen;

  logic [DISTINCT-1:0] hit_comb;
  logic [DISTINCT-1:0] free_comb;
  logic [DISTINCT-1:0] not_valid;
  logic [DISTINCT-1:0] hit_vec;
  logic [DISTINCT-1:0] free_vec;

  logic [COUNT_BITS-1:0]              sel_count;
  logic                               hit_any;
  logic                               free_any;
  logic [COUNT_BITS-1:0]              c_new;
  logic                               counted;
  logic                               best_update;
  logic [DISTINCT-1:0]                write_en;
  logic                               any_next;
  logic                               overflow_next;
  logic signed [smf_pkg::VALUE_W-1:0] best_value_next;
  logic [COUNT_BITS-1:0]              best_count_next;
  logic [WIDE_W-1:0]                  best_wide;

  assign status.last = last_q;
  assign status.out_blocked = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_q <= value;
      has_q <= has_value;
      last_q <= last;
    end
  end

  // match against all entries, pick the lowest free one
  always_comb begin
    for (int i = 0; i < DISTINCT; i++) begin
      hit_comb[i] = entry_valid[i] && (key_store[i] == value_q);
    end
  end

  assign not_valid = ~entry_valid;
  assign free_comb = not_valid & (~not_valid + DISTINCT'(1));

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      hit_vec <= hit_comb;
      free_vec <= free_comb;
    end
  end

  always_comb begin
    sel_count = '0;
    for (int i = 0; i < DISTINCT; i++) begin
      sel_count = sel_count | (count_store[i] & {COUNT_BITS{hit_vec[i]}});
    end
  end

  assign hit_any = |hit_vec;
  assign free_any = |free_vec;
  assign c_new = hit_any ? ((sel_count == COUNT_MAX) ? sel_count :
                            COUNT_BITS'(sel_count + 1'b1))
                         : COUNT_BITS'(1);
  assign counted = has_q && (hit_any || free_any);
  assign best_update = counted && (c_new > best_count);
  assign write_en = {DISTINCT{has_q}} & (hit_vec | (free_vec & {DISTINCT{!hit_any}}));

  assign any_next = any_seen || has_q;
  assign overflow_next = overflow_seen || (has_q && !hit_any && !free_any);
  assign best_value_next = best_update ? value_q : best_value;
  assign best_count_next = best_update ? c_new : best_count;
  assign best_wide = WIDE_W'(best_count_next);

  always_ff @(posedge clk) begin
    for (int i = 0; i < DISTINCT; i++) begin
      if (cmd.update && write_en[i]) begin
        key_store[i] <= value_q;
        count_store[i] <= c_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      entry_valid <= '0;
      best_value <= '0;
      best_count <= '0;
      overflow_seen <= 1'b0;
      any_seen <= 1'b0;
    end else if (cmd.update) begin
      entry_valid <= entry_valid | write_en;
      best_value <= best_value_next;
      best_count <= best_count_next;
      overflow_seen <= overflow_next;
      any_seen <= any_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (any_next) begin
        mode_value <= best_value_next;
        mode_count <= (best_wide > WIDE_W'(smf_pkg::MODE_COUNT_MAX)) ?
                      smf_pkg::MODE_COUNT_MAX : best_wide[smf_pkg::MODE_COUNT_W-1:0];
        empty_list <= 1'b0;
        table_overflow <= overflow_next;
      end else begin
        mode_value <= smf_pkg::EMPTY_VALUE;
        mode_count <= '0;
        empty_list <= 1'b1;
        table_overflow <= 1'b0;
      end
    end
  end

  a_hit_unique: assert property (@(posedge clk) disable iff (rst) $onehot0(hit_comb))
    else $error("value matches more than one table entry");

  a_clear_on_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (entry_valid == '0) && !any_seen && !overflow_seen)
    else $error("table not cleared after result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(out_valid && out_stall))
    else $error("result register overwritten while stalled");

endmodule

FILE: sv/stream_mode_finder_core.sv
// ----------------------------------------------------------------------------
// stream_mode_finder_core
// Streaming mode finder: counts signed values in an associative table and
// reports the most frequent value of each list on its last item.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   value, has_value, last
//   out      output     out_valid/out_stall mode_value, mode_count,
//                                           empty_list, table_overflow
//
// Each item passes through accept, parallel match of all DISTINCT entries,
// then table and mode update; the match/update sequencer sets the rate.
// The result is registered in the update step and appears in the cycle after it.
// Reset clears the table valid bits and running state at once.
// A last item waits in its update step while a stalled result is pending.
// ----------------------------------------------------------------------------
module stream_mode_finder_core #(
  parameter int DISTINCT = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [smf_pkg::VALUE_W-1:0] value,
  input  logic                               has_value,
  input  logic                               last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [smf_pkg::VALUE_W-1:0] mode_value,
  output logic [smf_pkg::MODE_COUNT_W-1:0]   mode_count,
  output logic                               empty_list,
  output logic                               table_overflow
);

  smf_pkg::cmd_t    cmd;
  smf_pkg::status_t status;

  smf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  smf_datapath #(
    .DISTINCT   (DISTINCT),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .value          (value),
    .has_value      (has_value),
    .last           (last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .mode_value     (mode_value),
    .mode_count     (mode_count),
    .empty_list     (empty_list),
    .table_overflow (table_overflow)
  );

endmodule
